>>> rtl/rrts_pkg.sv
// Package for the round-robin task scheduler: table geometry, action codes,
// slot mode codes and the command and status structs between controller and datapath.
// No dependencies.
package rrts_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int TASK_W = 8;
    localparam int DATA_W = 32;
    localparam int ACT_W  = 3;
    localparam int MODE_W = 2;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 16;

    localparam logic [ACT_W-1:0] ACT_SCHED  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_EXIT   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_WAIT   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_NOTIFY = 3'd4;
    localparam logic [ACT_W-1:0] ACT_SLEEP  = 3'd5;

    localparam logic [MODE_W-1:0] MODE_READY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SLEEP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WAIT  = 2'd2;

    typedef struct packed {
        logic start;     // latch a new input word and rewind the scan
        logic step;      // visit one slot
        logic load_out;  // copy the result into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic skip;      // the latched action touches no slot
        logic stop;      // this slot ends the scan early
        logic last;      // this is the final slot of the scan
    } dp_stat_t;

endpackage

>>> rtl/rrts_dp.sv
// Datapath of the round-robin task scheduler: slot table, scan counter,
// rotating pointer, current task and output register. Depends on rrts_pkg.
module rrts_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rrts_pkg::dp_cmd_t                   cmd,
    output rrts_pkg::dp_stat_t                  stat,
    input  logic [rrts_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic [rrts_pkg::M_TDATA_W-1:0]      m_tdata
);

    logic                          slot_valid_reg [rrts_pkg::SLOTS];
    logic [rrts_pkg::TASK_W-1:0]   slot_task_reg  [rrts_pkg::SLOTS];
    logic [rrts_pkg::MODE_W-1:0]   slot_mode_reg  [rrts_pkg::SLOTS];
    logic [rrts_pkg::DATA_W-1:0]   slot_data_reg  [rrts_pkg::SLOTS];

    logic [rrts_pkg::SLOT_W-1:0]   ptr_reg;
    logic [rrts_pkg::SLOT_W-1:0]   cnt_reg;
    logic [rrts_pkg::TASK_W-1:0]   cur_task_reg;
    logic                          cur_idle_reg;
    logic                          status_reg;

    logic [rrts_pkg::ACT_W-1:0]    act_reg;
    logic [rrts_pkg::TASK_W-1:0]   id_reg;
    logic [rrts_pkg::DATA_W-1:0]   key_reg;
    logic [rrts_pkg::DATA_W-1:0]   wake_reg;
    logic [rrts_pkg::DATA_W-1:0]   now_reg;

    logic [rrts_pkg::TASK_W-1:0]   out_task_reg;
    logic                          out_idle_reg;
    logic                          out_status_reg;

    logic [rrts_pkg::SLOT_W-1:0]   ptr_inc;
    logic [rrts_pkg::SLOT_W-1:0]   idx;
    logic                          v;
    logic [rrts_pkg::TASK_W-1:0]   t;
    logic [rrts_pkg::MODE_W-1:0]   m;
    logic [rrts_pkg::DATA_W-1:0]   d;
    logic                          is_sleep;
    logic                          is_wait;
    logic                          grant;

    // Schedule walks from the slot after the pointer; everything else walks from slot zero.
    assign ptr_inc = (ptr_reg == rrts_pkg::SLOT_W'(rrts_pkg::SLOTS - 1)) ? '0
                   : ptr_reg + 1'b1;
    assign idx     = (act_reg == rrts_pkg::ACT_SCHED) ? ptr_inc : cnt_reg;

    assign v        = slot_valid_reg[idx];
    assign t        = slot_task_reg[idx];
    assign m        = slot_mode_reg[idx];
    assign d        = slot_data_reg[idx];
    assign is_sleep = (m == rrts_pkg::MODE_SLEEP);
    assign is_wait  = (m == rrts_pkg::MODE_WAIT);
    // The unused mode code counts as ready.
    assign grant    = v && ((!is_sleep && !is_wait) || (is_sleep && (d < now_reg)));

    always_comb begin
        stat.last = (cnt_reg == rrts_pkg::SLOT_W'(rrts_pkg::SLOTS - 1));
        stat.stop = ((act_reg == rrts_pkg::ACT_SCHED) && grant)
                 || ((act_reg == rrts_pkg::ACT_ADD) && !v);
        unique case (act_reg)
            rrts_pkg::ACT_SCHED,
            rrts_pkg::ACT_ADD,
            rrts_pkg::ACT_EXIT,
            rrts_pkg::ACT_NOTIFY,
            rrts_pkg::ACT_SLEEP: stat.skip = 1'b0;
            rrts_pkg::ACT_WAIT:  stat.skip = cur_idle_reg;
            default:             stat.skip = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            act_reg  <= s_tdata[2:0];
            id_reg   <= s_tdata[10:3];
            key_reg  <= s_tdata[42:11];
            wake_reg <= s_tdata[74:43];
            now_reg  <= s_tdata[106:75];
        end
        if (cmd.load_out) begin
            out_task_reg   <= cur_task_reg;
            out_idle_reg   <= cur_idle_reg;
            out_status_reg <= status_reg;
        end
        if (cmd.step) begin
            unique case (act_reg)
                rrts_pkg::ACT_SCHED: begin
                    if (grant && is_sleep) begin
                        slot_mode_reg[idx] <= rrts_pkg::MODE_READY;
                    end
                end
                rrts_pkg::ACT_ADD: begin
                    if (!v) begin
                        slot_task_reg[idx] <= id_reg;
                        slot_mode_reg[idx] <= rrts_pkg::MODE_READY;
                        slot_data_reg[idx] <= '0;
                    end
                end
                rrts_pkg::ACT_WAIT: begin
                    if (v && (t == cur_task_reg)) begin
                        slot_mode_reg[idx] <= rrts_pkg::MODE_WAIT;
                        slot_data_reg[idx] <= key_reg;
                    end
                end
                rrts_pkg::ACT_NOTIFY: begin
                    if (v && is_wait && (d == key_reg)) begin
                        slot_mode_reg[idx] <= rrts_pkg::MODE_READY;
                        slot_data_reg[idx] <= '0;
                    end
                end
                rrts_pkg::ACT_SLEEP: begin
                    if (v && (t == id_reg)) begin
                        slot_mode_reg[idx] <= rrts_pkg::MODE_SLEEP;
                        slot_data_reg[idx] <= wake_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < rrts_pkg::SLOTS; k++) begin
                slot_valid_reg[k] <= 1'b0;
            end
            ptr_reg      <= '0;
            cnt_reg      <= '0;
            cur_task_reg <= '0;
            cur_idle_reg <= 1'b1;
            status_reg   <= 1'b0;
        end else if (cmd.start) begin
            cnt_reg    <= '0;
            status_reg <= 1'b0;
        end else if (cmd.step) begin
            cnt_reg <= cnt_reg + 1'b1;
            unique case (act_reg)
                rrts_pkg::ACT_SCHED: begin
                    ptr_reg <= idx;
                    if (grant) begin
                        cur_task_reg <= t;
                        cur_idle_reg <= 1'b0;
                    end else if (stat.last) begin
                        cur_task_reg <= '0;
                        cur_idle_reg <= 1'b1;
                    end
                end
                rrts_pkg::ACT_ADD: begin
                    if (!v) begin
                        slot_valid_reg[idx] <= 1'b1;
                    end else if (stat.last) begin
                        status_reg <= 1'b1;
                    end
                end
                rrts_pkg::ACT_EXIT: begin
                    if (v && (t == id_reg)) begin
                        slot_valid_reg[idx] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_tdata = {6'b0, out_status_reg, out_idle_reg, out_task_reg};

endmodule

>>> rtl/rrts_ctrl.sv
// Controller of the round-robin task scheduler: accept, scan and deliver states
// plus the output valid flag. Depends on rrts_pkg.
module rrts_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  rrts_pkg::dp_stat_t stat,
    output rrts_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd.start    = s_tvalid && (state_reg == ST_IDLE);
        cmd.step     = (state_reg == ST_SCAN) && !stat.skip;
        cmd.load_out = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.skip || stat.stop || stat.last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (cmd.load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

>>> rtl/round_robin_task_scheduler.sv
// Top level of the round-robin task scheduler: joins the controller and the datapath.
// Depends on rrts_pkg, rrts_ctrl and rrts_dp.
//
// Usage: each word on the slave stream carries one action (schedule, add, exit,
// wait, notify, sleep) against an eight-slot task table, and produces exactly
// one word on the master stream with the current task, the idle flag and the
// add-full status. Unused action codes leave the table alone and still answer.
// A word is taken in the idle state, then the controller walks the table one slot a
// cycle through the single slot port of the datapath: add stops at the first
// free slot, schedule stops at the first runnable slot after the rotating
// pointer, exit, notify and sleep always visit all slots, and so does wait
// unless the idle task is current, in which case it visits none. The deliver
// state then moves the result into the output register.
// s_tready is high only between items, so one item is at work at a time; the
// output register lets the next word be accepted while a result still waits.
// If the receiver stalls with a result pending, the next item runs its scan
// and then holds in the deliver state until the output register drains.
// Synchronous active-low reset empties the table, clears the pointer, makes the
// idle task current and drops m_tvalid.
module round_robin_task_scheduler (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, lowest bit up: action[2:0], task_id[10:3], event_key[42:11],
    // wake_tick[74:43], now_tick[106:75], zero[111:107]
    input  logic [rrts_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, lowest bit up: granted_task[7:0], granted_idle[8], status[9],
    // zero[15:10]
    output logic [rrts_pkg::M_TDATA_W-1:0]    m_tdata
);

    rrts_pkg::dp_cmd_t  cmd;
    rrts_pkg::dp_stat_t stat;

    rrts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rrts_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

>>> rtl/rrts_checker.sv
// Port-level checks for the round-robin task scheduler, bound to the top level.
// Depends on rrts_pkg and round_robin_task_scheduler.
module rrts_port_checks (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [rrts_pkg::S_TDATA_W-1:0]    s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [rrts_pkg::M_TDATA_W-1:0]    m_tdata
);

    // Reset drops the output valid on the following edge.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid not cleared by reset");

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // One item at a time: after an accept the input side closes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is at work");

    // The idle task always reports task id zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> (m_tdata[7:0] == 8'd0))
        else $error("idle grant with nonzero task id");

    // Padding bits of the result word stay zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:10] == 6'd0))
        else $error("nonzero padding in result word");

endmodule

bind round_robin_task_scheduler rrts_port_checks u_rrts_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
